// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the compositor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VRSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VRSC_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define VRSC_ASSERT(lbl, clk, rstn, prop, msg)
`define VRSC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/vrsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vrsc_pkg
// types and constants of the volume ray sample compositor
// ----------------------------------------------------------------------------
`default_nettype none
package vrsc_pkg;

  localparam int EXP_TABLE_DEPTH = 256;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [15:0] T_STOP  = 16'd82;

  // register reset values
  localparam logic [15:0] KAPPA_RST  = 16'd5734;
  localparam logic [15:0] INVK_RST   = 16'd5851;
  localparam logic [7:0]  BACK_R_RST = 8'd69;
  localparam logic [7:0]  BACK_G_RST = 8'd130;
  localparam logic [7:0]  BACK_B_RST = 8'd181;

  // register indexes
  localparam logic [2:0] REG_KAPPA  = 3'd0;
  localparam logic [2:0] REG_INVK   = 3'd1;
  localparam logic [2:0] REG_BACK_R = 3'd2;
  localparam logic [2:0] REG_BACK_G = 3'd3;
  localparam logic [2:0] REG_BACK_B = 3'd4;

  // color channel codes
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef struct packed {
    logic [15:0] kappa_step;
    logic [15:0] inv_kappa;
    logic [7:0]  back_red;
    logic [7:0]  back_green;
    logic [7:0]  back_blue;
  } vrsc_cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       xmul;
    logic       lookup;
    logic       trans;
    logic       issue_v;
    logic [1:0] issue_ch;
    logic       emit_v;
    logic [1:0] emit_ch;
    logic       out_load;
  } vrsc_cmd_t;

  typedef struct packed {
    logic active;
    logic opaque;
    logic last;
  } vrsc_sts_t;

endpackage
`default_nettype wire

// ===== rtl/vrsc_cfg.sv =====
// ----------------------------------------------------------------------------
// vrsc_cfg
// apb register file for absorption, reciprocal and background color
// ----------------------------------------------------------------------------
`default_nettype none
module vrsc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output vrsc_pkg::vrsc_cfg_t cfg_o
);
  import vrsc_pkg::*;

  vrsc_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KAPPA:  cfg_d.kappa_step = pwdata[15:0];
        REG_INVK:   cfg_d.inv_kappa  = pwdata[15:0];
        REG_BACK_R: cfg_d.back_red   = pwdata[7:0];
        REG_BACK_G: cfg_d.back_green = pwdata[7:0];
        REG_BACK_B: cfg_d.back_blue  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{KAPPA_RST, INVK_RST, BACK_R_RST, BACK_G_RST, BACK_B_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_KAPPA:  prdata = {16'd0, cfg_q.kappa_step};
      REG_INVK:   prdata = {16'd0, cfg_q.inv_kappa};
      REG_BACK_R: prdata = {24'd0, cfg_q.back_red};
      REG_BACK_G: prdata = {24'd0, cfg_q.back_green};
      REG_BACK_B: prdata = {24'd0, cfg_q.back_blue};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/vrsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrsc_ctrl
// sequencer for sample lookup, color accumulation and pixel emission
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vrsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vrsc_pkg::vrsc_sts_t sts_i,
  output vrsc_pkg::vrsc_cmd_t cmd_o
);
  import vrsc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XMUL   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_TRANS  = 3'd3;
  localparam logic [2:0] S_COLOR  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [2:0] COLOR_LAST = 3'd4;
  localparam logic [2:0] EMIT_LAST  = 3'd2;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_XMUL;
        end
      end
      S_XMUL: begin
        cmd_o.xmul = 1'b1;
        state_d    = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_TRANS;
      end
      S_TRANS: begin
        cmd_o.trans = 1'b1;
        step_d      = 3'd0;
        if (sts_i.active && !sts_i.opaque) begin
          state_d = S_COLOR;
        end else if (sts_i.last) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_COLOR: begin
        cmd_o.issue_v  = (step_q < 3'd3);
        cmd_o.issue_ch = step_q[1:0];
        step_d         = step_q + 3'd1;
        if (step_q == COLOR_LAST) begin
          step_d  = 3'd0;
          state_d = sts_i.last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit_v  = 1'b1;
        cmd_o.emit_ch = step_q[1:0];
        step_d        = step_q + 3'd1;
        if (step_q == EMIT_LAST) begin
          step_d  = 3'd0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `VRSC_ASSERT(a_accept_starts, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_XMUL), "accepted sample did not start")
  `VRSC_NEVER(a_load_overwrite, clk_i, rst_ni, cmd_o.out_load && out_valid_q && !out_ready_i, "pending pixel overwritten")
  `VRSC_ASSERT(a_color_ends, clk_i, rst_ni, (state_q == S_COLOR && step_q == COLOR_LAST) |=> (state_q != S_COLOR), "color loop overran")

endmodule
`default_nettype wire

// ===== rtl/vrsc_dp.sv =====
// ----------------------------------------------------------------------------
// vrsc_dp
// compositing datapath: exp lookup, transmittance, color sums, emission
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vrsc_dp #(
  parameter int ExpTableDepth = vrsc_pkg::EXP_TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrsc_pkg::vrsc_cfg_t cfg_i,
  input  vrsc_pkg::vrsc_cmd_t cmd_i,
  output vrsc_pkg::vrsc_sts_t sts_o,
  input  logic [15:0]         density_i,
  input  logic [7:0]          color_r_i,
  input  logic [7:0]          color_g_i,
  input  logic [7:0]          color_b_i,
  input  logic [15:0]         light_a_i,
  input  logic [15:0]         light_b_i,
  input  logic                sample_valid_i,
  input  logic                last_sample_i,
  output logic [7:0]          pixel_r_o,
  output logic [7:0]          pixel_g_o,
  output logic [7:0]          pixel_b_o,
  output logic                ray_opaque_o
);
  import vrsc_pkg::*;

  localparam int IdxW     = $clog2(ExpTableDepth);
  localparam int IdxProdW = 33 + IdxW;

  typedef logic [15:0] exp_tab_t [ExpTableDepth];

  // exp(-8/depth) series, then repeated powers, rounded to q1.15
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] base;
    logic [63:0] e;
    term = 64'd1 << 30;
    pos  = term;
    neg  = 64'd0;
    term = (term * 8) / ExpTableDepth;        neg = neg + term;
    term = (term * 8) / ExpTableDepth / 2;    pos = pos + term;
    term = (term * 8) / ExpTableDepth / 3;    neg = neg + term;
    term = (term * 8) / ExpTableDepth / 4;    pos = pos + term;
    term = (term * 8) / ExpTableDepth / 5;    neg = neg + term;
    term = (term * 8) / ExpTableDepth / 6;    pos = pos + term;
    term = (term * 8) / ExpTableDepth / 7;    neg = neg + term;
    term = (term * 8) / ExpTableDepth / 8;    pos = pos + term;
    term = (term * 8) / ExpTableDepth / 9;    neg = neg + term;
    term = (term * 8) / ExpTableDepth / 10;   pos = pos + term;
    term = (term * 8) / ExpTableDepth / 11;   neg = neg + term;
    term = (term * 8) / ExpTableDepth / 12;   pos = pos + term;
    base = pos - neg;
    e    = 64'd1 << 30;
    for (int i = 0; i < ExpTableDepth; i++) begin
      tab[i] = 16'((e + (64'd1 << 14)) >> 15);
      e      = (e * base + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // captured sample
  logic [15:0] dens_q, la_q, lb_q;
  logic [7:0]  cr_q, cg_q, cb_q;
  logic        valid_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      dens_q  <= density_i;
      cr_q    <= color_r_i;
      cg_q    <= color_g_i;
      cb_q    <= color_b_i;
      la_q    <= light_a_i;
      lb_q    <= light_b_i;
      valid_q <= sample_valid_i;
      last_q  <= last_sample_i;
    end
  end

  // optical depth product and combined light
  logic [31:0] x_q;
  logic [15:0] light_q, light_d, la_c, lb_c;
  logic [16:0] light_sum;

  always_comb begin
    la_c      = (la_q > ONE_Q15) ? ONE_Q15 : la_q;
    lb_c      = (lb_q > ONE_Q15) ? ONE_Q15 : lb_q;
    light_sum = {1'b0, la_c} + {1'b0, lb_c};
    if (light_sum > {1'b0, ONE_Q15}) begin
      light_d = (la_c > lb_c) ? la_c : lb_c;
    end else begin
      light_d = light_sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xmul) begin
      x_q     <= cfg_i.kappa_step * dens_q;
      light_q <= light_d;
    end
  end

  // table lookup
  logic [IdxProdW-1:0] idx_prod;
  logic [IdxW+3:0]     idx_full;
  logic [15:0]         delta_q;

  assign idx_prod = {{(IdxProdW-32){1'b0}}, x_q} * IdxProdW'(ExpTableDepth);
  assign idx_full = idx_prod[IdxProdW-1:29];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      if (idx_full < (IdxW+4)'(ExpTableDepth)) begin
        delta_q <= EXP_TAB[idx_full[IdxW-1:0]];
      end else begin
        delta_q <= 16'd0;
      end
    end
  end

  // transmittance update
  logic [31:0] t_prod;
  logic [15:0] t_new, om;
  logic [15:0] t_q;
  logic        done_q;
  logic [31:0] a_q;
  logic        active;

  assign t_prod = t_q * delta_q;
  assign t_new  = t_prod[30:15];
  assign om     = ONE_Q15 - delta_q;
  assign active = valid_q && !done_q;

  assign sts_o.active = active;
  assign sts_o.opaque = (t_new < T_STOP);
  assign sts_o.last   = last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.trans) a_q <= om * cfg_i.inv_kappa;
  end

  // color contribution pipeline, one channel issued per cycle
  logic [7:0]  col_sel;
  logic [39:0] m1_q;
  logic [55:0] m2_prod;
  logic [40:0] m2_q;
  logic [56:0] m3_prod;
  logic [14:0] m3;
  logic        v1_q, v2_q;
  logic [1:0]  ch1_q, ch2_q;
  logic [15:0] sum_r_q, sum_g_q, sum_b_q, acc_sel;
  logic [16:0] acc_sum;
  logic [15:0] acc_new;

  always_comb begin
    case (cmd_i.issue_ch)
      CH_R:    col_sel = cr_q;
      CH_G:    col_sel = cg_q;
      CH_B:    col_sel = cb_q;
      default: col_sel = 8'd0;
    endcase
  end

  assign m2_prod = m1_q * t_q;
  assign m3_prod = m2_q * light_q;
  assign m3      = m3_prod[56:42];

  always_comb begin
    case (ch2_q)
      CH_R:    acc_sel = sum_r_q;
      CH_G:    acc_sel = sum_g_q;
      CH_B:    acc_sel = sum_b_q;
      default: acc_sel = 16'd0;
    endcase
    acc_sum = {1'b0, acc_sel} + {2'b0, m3};
    acc_new = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_v) m1_q <= a_q * col_sel;
    if (v1_q) m2_q <= m2_prod[55:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ch1_q <= CH_R;
      ch2_q <= CH_R;
    end else begin
      v1_q  <= cmd_i.issue_v;
      v2_q  <= v1_q;
      ch1_q <= cmd_i.issue_ch;
      ch2_q <= ch1_q;
    end
  end

  // ray state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q     <= ONE_Q15;
      done_q  <= 1'b0;
      sum_r_q <= 16'd0;
      sum_g_q <= 16'd0;
      sum_b_q <= 16'd0;
    end else if (cmd_i.out_load) begin
      t_q     <= ONE_Q15;
      done_q  <= 1'b0;
      sum_r_q <= 16'd0;
      sum_g_q <= 16'd0;
      sum_b_q <= 16'd0;
    end else begin
      if (cmd_i.trans && active) begin
        t_q <= t_new;
        if (t_new < T_STOP) done_q <= 1'b1;
      end
      if (v2_q) begin
        case (ch2_q)
          CH_R:    sum_r_q <= acc_new;
          CH_G:    sum_g_q <= acc_new;
          CH_B:    sum_b_q <= acc_new;
          default: ;
        endcase
      end
    end
  end

  // background blend (saturated sum for an opaque ray), one channel per cycle
  logic [15:0] emit_sum;
  logic [7:0]  emit_back;
  logic [15:0] t_inv;
  logic [31:0] blend_a;
  logic [23:0] blend_b;
  logic [32:0] blend;
  logic [17:0] blend_sh;
  logic [7:0]  emit_pix;
  logic [7:0]  pix_r_q, pix_g_q, pix_b_q;

  always_comb begin
    case (cmd_i.emit_ch)
      CH_R: begin
        emit_sum  = sum_r_q;
        emit_back = cfg_i.back_red;
      end
      CH_G: begin
        emit_sum  = sum_g_q;
        emit_back = cfg_i.back_green;
      end
      CH_B: begin
        emit_sum  = sum_b_q;
        emit_back = cfg_i.back_blue;
      end
      default: begin
        emit_sum  = 16'd0;
        emit_back = 8'd0;
      end
    endcase
    t_inv    = ONE_Q15 - t_q;
    blend_a  = emit_sum * t_inv;
    blend_b  = emit_back * t_q;
    blend    = {1'b0, blend_a} + {9'd0, blend_b};
    blend_sh = blend[32:15];
    if (done_q) begin
      emit_pix = (emit_sum > 16'd255) ? 8'hFF : emit_sum[7:0];
    end else begin
      emit_pix = (blend_sh > 18'd255) ? 8'hFF : blend_sh[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_v) begin
      case (cmd_i.emit_ch)
        CH_R:    pix_r_q <= emit_pix;
        CH_G:    pix_g_q <= emit_pix;
        CH_B:    pix_b_q <= emit_pix;
        default: ;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_r_o    <= pix_r_q;
      pixel_g_o    <= pix_g_q;
      pixel_b_o    <= pix_b_q;
      ray_opaque_o <= done_q;
    end
  end

  `VRSC_ASSERT(a_done_dark, clk_i, rst_ni, done_q |-> (t_q < T_STOP), "opaque ray with high transmittance")
  `VRSC_ASSERT(a_t_falls, clk_i, rst_ni, (cmd_i.trans && !cmd_i.out_load) |=> (t_q <= $past(t_q)), "transmittance rose")
  `VRSC_NEVER(a_drained, clk_i, rst_ni, cmd_i.out_load && (v1_q || v2_q), "emit with color pipeline busy")

endmodule
`default_nettype wire

// ===== rtl/volume_ray_sample_compositor_unit.sv =====
// sequence: an accepted sample runs the xmul, lookup and trans states, then color if it adds color
// a new sample is accepted only once the last one is finished; the color state drains the
//   shared three-stage color multiplier chain issued one channel per cycle
// a last sample then runs the per-channel background blend and output load before its pixel beat
// reset: async active-low; ray state clears to transmittance one, registers to defaults
// ----------------------------------------------------------------------------
// volume_ray_sample_compositor_unit
// front-to-back compositing of ray samples into saturated rgb pixels
// ----------------------------------------------------------------------------
`default_nettype none
module volume_ray_sample_compositor_unit #(
  parameter int ExpTableDepth = vrsc_pkg::EXP_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // density[15:0] color_r[23:16] color_g[31:24] color_b[39:32]
  // light_a[55:40] light_b[71:56]
  input  logic [71:0] s_axis_tdata,
  // sample_valid[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // pixel stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_r[7:0] pixel_g[15:8] pixel_b[23:16]
  output logic [23:0] m_axis_tdata,
  // ray_opaque[0]
  output logic        m_axis_tuser
);
  import vrsc_pkg::*;

  vrsc_cfg_t cfg;
  vrsc_cmd_t cmd;
  vrsc_sts_t sts;

  vrsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vrsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vrsc_dp #(
    .ExpTableDepth (ExpTableDepth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .density_i      (s_axis_tdata[15:0]),
    .color_r_i      (s_axis_tdata[23:16]),
    .color_g_i      (s_axis_tdata[31:24]),
    .color_b_i      (s_axis_tdata[39:32]),
    .light_a_i      (s_axis_tdata[55:40]),
    .light_b_i      (s_axis_tdata[71:56]),
    .sample_valid_i (s_axis_tuser),
    .last_sample_i  (s_axis_tlast),
    .pixel_r_o      (m_axis_tdata[7:0]),
    .pixel_g_o      (m_axis_tdata[15:8]),
    .pixel_b_o      (m_axis_tdata[23:16]),
    .ray_opaque_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire
